// ----- src/tsw_pkg.sv -----
// shared types and constants for the tft spi register and pixel writer
// no dependencies
package tsw_pkg;

    localparam logic [1:0] ACT_REG_WRITE = 2'd0;
    localparam logic [1:0] ACT_INDEX     = 2'd1;
    localparam logic [1:0] ACT_DATA      = 2'd2;
    localparam logic [1:0] ACT_PIXEL     = 2'd3;

    localparam logic [7:0] START_INDEX = 8'h70;
    localparam logic [7:0] START_DATA  = 8'h72;
    localparam logic [7:0] REG_GRAM    = 8'h22;
    localparam logic [7:0] REG_COL_LO  = 8'h03;
    localparam logic [7:0] REG_COL_HI  = 8'h02;
    localparam logic [7:0] REG_ROW_LO  = 8'h07;
    localparam logic [7:0] REG_ROW_HI  = 8'h06;

    // byte positions inside one register write
    localparam logic [2:0] STEP_IDX_START = 3'd0;
    localparam logic [2:0] STEP_IDX_REG   = 3'd1;
    localparam logic [2:0] STEP_DAT_START = 3'd2;
    localparam logic [2:0] STEP_DAT_HI    = 3'd3;
    localparam logic [2:0] STEP_DAT_LO    = 3'd4;

    localparam logic [2:0] GRP_COL_LO = 3'd0;
    localparam logic [2:0] GRP_COL_HI = 3'd1;
    localparam logic [2:0] GRP_ROW_LO = 3'd2;
    localparam logic [2:0] GRP_ROW_HI = 3'd3;
    localparam logic [2:0] GRP_GRAM   = 3'd4;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  reg_index;
        logic [15:0] word_value;
        logic [8:0]  col;
        logic [8:0]  row;
    } t_in_item;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       frame_end;
        logic       last;
    } t_out_item;

    // classified request handed from front to back
    typedef struct packed {
        logic        pixel;
        logic [2:0]  start_step;
        logic [2:0]  end_step;
        logic [2:0]  last_grp;
        logic [7:0]  reg_index;
        logic [15:0] word_value;
        logic [8:0]  col;
        logic [8:0]  row;
    } t_cmd;

endpackage

// ----- src/tsw_front.sv -----
// request classifier: maps an action onto a range of register-write bytes
// depends on tsw_pkg
module tsw_front (
    input  tsw_pkg::t_in_item i_item,
    output tsw_pkg::t_cmd     o_cmd
);

    always_comb begin
        o_cmd.pixel      = 1'b0;
        o_cmd.reg_index  = i_item.reg_index;
        o_cmd.word_value = i_item.word_value;
        o_cmd.col        = i_item.col;
        o_cmd.row        = i_item.row;
        o_cmd.start_step = tsw_pkg::STEP_IDX_START;
        o_cmd.end_step   = tsw_pkg::STEP_DAT_LO;
        o_cmd.last_grp   = tsw_pkg::GRP_COL_LO;
        unique case (i_item.action)
            tsw_pkg::ACT_REG_WRITE: begin
            end
            tsw_pkg::ACT_INDEX: begin
                o_cmd.end_step = tsw_pkg::STEP_IDX_REG;
            end
            tsw_pkg::ACT_DATA: begin
                o_cmd.start_step = tsw_pkg::STEP_DAT_START;
            end
            tsw_pkg::ACT_PIXEL: begin
                o_cmd.pixel    = 1'b1;
                o_cmd.last_grp = tsw_pkg::GRP_GRAM;
            end
        endcase
    end

endmodule

// ----- src/tsw_queue.sv -----
// two-entry command queue between classifier and byte sequencer
// depends on tsw_pkg
module tsw_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tsw_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output tsw_pkg::t_cmd o_cmd
);

    localparam int PW = $clog2(tsw_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(tsw_pkg::QUEUE_DEPTH + 1);

    tsw_pkg::t_cmd r_mem [tsw_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(tsw_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wp  = do_push ? PW'(r_wp + 1'b1) : r_wp;
        n_rp  = do_pop ? PW'(r_rp + 1'b1) : r_rp;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = CW'(r_cnt + 1'b1);
        end else if (do_pop && !do_push) begin
            n_cnt = CW'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

// ----- src/tsw_back.sv -----
// byte sequencer walks register-write groups, one spi byte per unstalled cycle
// depends on tsw_pkg
module tsw_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  tsw_pkg::t_cmd     i_cmd,
    output logic              o_pop,
    output logic              o_out_valid,
    output tsw_pkg::t_out_item o_out_item,
    input  logic              i_out_stall
);

    logic               r_busy, n_busy;
    logic [2:0]         r_step, n_step;
    logic [2:0]         r_grp, n_grp;
    logic               r_out_valid, n_out_valid;
    tsw_pkg::t_out_item r_out_item;
    tsw_pkg::t_out_item cur_item;
    logic [2:0]         step, grp;
    logic [7:0]         grp_reg;
    logic [15:0]        grp_val;
    logic               advance, emit, is_last;

    // an idle sequencer starts at the head command's first byte
    assign step    = r_busy ? r_step : i_cmd.start_step;
    assign grp     = r_busy ? r_grp : tsw_pkg::GRP_COL_LO;
    assign advance = !r_out_valid || !i_out_stall;
    assign emit    = advance && i_cmd_valid;
    assign is_last = (grp == i_cmd.last_grp) && (step == i_cmd.end_step);
    assign o_pop   = emit && is_last;

    always_comb begin
        grp_reg = i_cmd.reg_index;
        grp_val = i_cmd.word_value;
        if (i_cmd.pixel) begin
            unique case (grp)
                tsw_pkg::GRP_COL_LO: begin
                    grp_reg = tsw_pkg::REG_COL_LO;
                    grp_val = {7'd0, i_cmd.col};
                end
                tsw_pkg::GRP_COL_HI: begin
                    grp_reg = tsw_pkg::REG_COL_HI;
                    grp_val = {15'd0, i_cmd.col[8]};
                end
                tsw_pkg::GRP_ROW_LO: begin
                    grp_reg = tsw_pkg::REG_ROW_LO;
                    grp_val = {7'd0, i_cmd.row};
                end
                tsw_pkg::GRP_ROW_HI: begin
                    grp_reg = tsw_pkg::REG_ROW_HI;
                    grp_val = {15'd0, i_cmd.row[8]};
                end
                default: begin
                    grp_reg = tsw_pkg::REG_GRAM;
                    grp_val = i_cmd.word_value;
                end
            endcase
        end
    end

    always_comb begin
        cur_item.last      = is_last;
        cur_item.frame_end = (step == tsw_pkg::STEP_IDX_REG) ||
                             (step == tsw_pkg::STEP_DAT_LO);
        unique case (step)
            tsw_pkg::STEP_IDX_START: cur_item.tx_byte = tsw_pkg::START_INDEX;
            tsw_pkg::STEP_IDX_REG:   cur_item.tx_byte = grp_reg;
            tsw_pkg::STEP_DAT_START: cur_item.tx_byte = tsw_pkg::START_DATA;
            tsw_pkg::STEP_DAT_HI:    cur_item.tx_byte = grp_val[15:8];
            default:                 cur_item.tx_byte = grp_val[7:0];
        endcase
    end

    always_comb begin
        n_busy      = r_busy;
        n_step      = r_step;
        n_grp       = r_grp;
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = i_cmd_valid;
        end
        if (emit) begin
            if (is_last) begin
                n_busy = 1'b0;
            end else begin
                n_busy = 1'b1;
                if (step == tsw_pkg::STEP_DAT_LO) begin
                    n_step = tsw_pkg::STEP_IDX_START;
                    n_grp  = 3'(grp + 1'b1);
                end else begin
                    n_step = 3'(step + 1'b1);
                    n_grp  = grp;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= tsw_pkg::STEP_IDX_START;
            r_grp       <= tsw_pkg::GRP_COL_LO;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_step      <= n_step;
            r_grp       <= n_grp;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_item <= cur_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ----- src/tft_spi_register_and_pixel_writer_top.sv -----
// tft spi register and pixel writer, top level
// a request is stored in the queue, and its bytes leave from the output register
// one byte per cycle, when not stalled, from the sequencer's output register; a
// request is 5 (register write), 2 (index), 3 (data) or 25 (pixel write) bytes
// a two-entry queue lets requests be taken while the sequencer is busy
// reset: synchronous active-low, empties the queue and the output register
module tft_spi_register_and_pixel_writer_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  tsw_pkg::t_in_item  i_in_item,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output tsw_pkg::t_out_item o_out_item,
    input  logic               i_out_stall
);

    tsw_pkg::t_cmd front_cmd;
    tsw_pkg::t_cmd head_cmd;
    logic          queue_full, head_valid, pop;

    tsw_front u_front (
        .i_item (i_in_item),
        .o_cmd  (front_cmd)
    );

    tsw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_valid (head_valid),
        .o_cmd   (head_cmd)
    );

    tsw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (head_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    assign o_in_stall = queue_full;

endmodule
